@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro samples on the rising clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

@@ hw/rtl/e2fdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package e2fdt_pkg;

	localparam logic [31:0] REBASE_SECS = 32'd63072000;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam logic [11:0] BASE_YEAR = 12'd1972;
	localparam logic [7:0] FAT_YEAR_OFFSET = 8'd8;
	localparam logic [31:0] RANGE_LOW = 32'd315532800;
	localparam logic [31:0] RANGE_HIGH = 32'd4102444799;

	// Reciprocals rounded up; each gives an exact floor over its input range.
	// (t >> 7) / 675 with shift 35, days / 1461 with shift 32,
	// tod / 3600 with shift 32, min_sec / 60 with shift 24.
	localparam logic [25:0] RECIP_DAY = 26'd50903317;
	localparam logic [21:0] RECIP_CYCLE = 22'd2939745;
	localparam logic [20:0] RECIP_HOUR = 21'd1193047;
	localparam logic [18:0] RECIP_MIN = 19'd279621;

	typedef logic [8:0] cum_t;

	localparam cum_t CUM_COMMON [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};
	localparam cum_t CUM_LEAP [12] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
	};

	// Days before the first of month idx (0 is January).
	function automatic cum_t cum_days(input logic leap, input logic [3:0] idx);
		cum_t val;
		val = '0;
		if (idx < 4'd12) begin
			val = leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
		end
		return val;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/epoch_to_fat_date_time_unit.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------------
// epoch    | epoch_valid / epoch_ready   | epoch_seconds[31:0]
// result   | result_valid / result_ready | year, month, day, hour, minute, second,
//          |                             | fat_date, fat_time, in_range
//
// Six register stages; a transaction enters every cycle unless the pipeline is
// stalled by result_ready. The reciprocal multipliers (day split, four-year
// cycle, hour, minute) sit in stages 1, 2, 3 and 5.
// arst_n clears only the stage valid bits; data registers are not reset.
// A stage holds while its successor is full and stalled, so bubbles are
// squeezed out and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module epoch_to_fat_date_time_unit import e2fdt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        epoch_valid,
	output logic             epoch_ready,
	input  wire logic [31:0] epoch_seconds,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	output logic [15:0]      fat_date,
	output logic [15:0]      fat_time,
	output logic             in_range
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || result_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign epoch_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= epoch_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: rebase to 1972 and start the whole-day division.
	logic [31:0] t_c;
	logic [31:0] t_s1;
	logic [50:0] pday_s1;
	logic        rng_s1;

	assign t_c = epoch_seconds - REBASE_SECS;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			t_s1    <= t_c;
			pday_s1 <= 51'(t_c[31:7]) * 51'(RECIP_DAY);
			rng_s1  <= (epoch_seconds >= RANGE_LOW) && (epoch_seconds <= RANGE_HIGH);
		end
	end

	// Stage 2: day count, time of day, and the four-year cycle product.
	logic [15:0] days_c;
	logic [32:0] day_secs_c;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;
	logic [37:0] pcyc_s2;
	logic        rng_s2;

	assign days_c = pday_s1[50:35];
	assign day_secs_c = 33'(days_c) * 33'(SECS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			days_s2 <= days_c;
			tod_s2  <= t_s1[16:0] - day_secs_c[16:0];
			pcyc_s2 <= 38'(days_c) * 38'(RECIP_CYCLE);
			rng_s2  <= rng_s1;
		end
	end

	// Stage 3: day within the four-year cycle, hour product.
	logic [5:0]  cyc_c;
	logic [15:0] cyc_days_c;
	logic [15:0] cday_c;
	logic [5:0]  cyc_s3;
	logic [10:0] cday_s3;
	logic [16:0] tod_s3;
	logic [37:0] phour_s3;
	logic        rng_s3;

	assign cyc_c = pcyc_s2[37:32];
	assign cyc_days_c = 16'(cyc_c) * 16'(DAYS_PER_CYCLE);
	assign cday_c = days_s2 - cyc_days_c;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cyc_s3   <= cyc_c;
			cday_s3  <= cday_c[10:0];
			tod_s3   <= tod_s2;
			phour_s3 <= 38'(tod_s2) * 38'(RECIP_HOUR);
			rng_s3   <= rng_s2;
		end
	end

	// Stage 4: year within the cycle, day of year, hour and seconds of hour.
	// The first year of every cycle is the leap year.
	logic [4:0]  hour_c;
	logic [16:0] hour_secs_c;
	logic [16:0] ms_c;
	logic [1:0]  yic_c;
	logic [10:0] ybase_c;
	logic [10:0] doy0_c;
	logic [4:0]  hour_s4;
	logic [11:0] ms_s4;
	logic [8:0]  doy0_s4;
	logic        leap_s4;
	logic [7:0]  yoff_s4;
	logic        rng_s4;

	assign hour_c = phour_s3[36:32];
	assign hour_secs_c = 17'(hour_c) * 17'(SECS_PER_HOUR);
	assign ms_c = tod_s3 - hour_secs_c;

	always_comb begin
		if (cday_s3 >= 11'd1096) begin
			yic_c = 2'd3;
			ybase_c = 11'd1096;
		end else if (cday_s3 >= 11'd731) begin
			yic_c = 2'd2;
			ybase_c = 11'd731;
		end else if (cday_s3 >= 11'd366) begin
			yic_c = 2'd1;
			ybase_c = 11'd366;
		end else begin
			yic_c = 2'd0;
			ybase_c = 11'd0;
		end
	end

	assign doy0_c = cday_s3 - ybase_c;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hour_s4 <= hour_c;
			ms_s4   <= ms_c[11:0];
			doy0_s4 <= doy0_c[8:0];
			leap_s4 <= (cday_s3 <= 11'd365);
			yoff_s4 <= {cyc_s3, 2'b00} + 8'(yic_c);
			rng_s4  <= rng_s3;
		end
	end

	// Stage 5: month and day of month, minute product.
	logic [8:0]  doy_c;
	logic [3:0]  month_c;
	cum_t        cum_sel_c;
	logic [8:0]  day_diff_c;
	logic [4:0]  hour_s5;
	logic [11:0] ms_s5;
	logic [30:0] pmin_s5;
	logic [3:0]  month_s5;
	logic [7:0]  day_s5;
	logic [7:0]  yoff_s5;
	logic        rng_s5;

	assign doy_c = doy0_s4 + 9'd1;

	always_comb begin
		month_c = 4'd1;
		for (int m = 1; m < 12; m++) begin
			if (doy_c > cum_days(leap_s4, 4'(m))) begin
				month_c = month_c + 4'd1;
			end
		end
	end

	assign cum_sel_c = cum_days(leap_s4, month_c - 4'd1);
	assign day_diff_c = doy_c - cum_sel_c;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			hour_s5  <= hour_s4;
			ms_s5    <= ms_s4;
			pmin_s5  <= 31'(ms_s4) * 31'(RECIP_MIN);
			month_s5 <= month_c;
			day_s5   <= day_diff_c[7:0];
			yoff_s5  <= yoff_s4;
			rng_s5   <= rng_s4;
		end
	end

	// Stage 6: minute and second, then the packed words into the output register.
	logic [5:0]  min_c;
	logic [11:0] min_secs_c;
	logic [11:0] sec_c;
	logic [7:0]  ydiff_c;
	logic [11:0] year_s6;
	logic [3:0]  month_s6;
	logic [7:0]  day_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  min_s6;
	logic [5:0]  sec_s6;
	logic [15:0] fdate_s6;
	logic [15:0] ftime_s6;
	logic        rng_s6;

	assign min_c = pmin_s5[29:24];
	assign min_secs_c = 12'(min_c) * 12'(SECS_PER_MIN);
	assign sec_c = ms_s5 - min_secs_c;
	assign ydiff_c = yoff_s5 - FAT_YEAR_OFFSET;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			year_s6  <= BASE_YEAR + 12'(yoff_s5);
			month_s6 <= month_s5;
			day_s6   <= day_s5;
			hour_s6  <= hour_s5;
			min_s6   <= min_c;
			sec_s6   <= sec_c[5:0];
			fdate_s6 <= {ydiff_c[6:0], 9'd0} | {7'd0, month_s5, 5'd0} | {8'd0, day_s5};
			ftime_s6 <= {hour_s5, min_c, sec_c[5:1]};
			rng_s6   <= rng_s5;
		end
	end

	assign result_valid = v_s6;
	assign year = year_s6;
	assign month = month_s6;
	assign day = day_s6[4:0];
	assign hour = hour_s6;
	assign minute = min_s6;
	assign second = sec_s6;
	assign fat_date = fdate_s6;
	assign fat_time = ftime_s6;
	assign in_range = rng_s6;

	// Reciprocal remainders stay below divisors, dates in range; accepted input sets v_s1.
	`ASSERT_SAME(a_tod_bound, clk, arst_n, v_s2, tod_s2 < SECS_PER_DAY)
	`ASSERT_SAME(a_cycle_bound, clk, arst_n, v_s3, cday_s3 < DAYS_PER_CYCLE)
	`ASSERT_SAME(a_doy_bound, clk, arst_n, v_s4, doy0_s4 <= 9'd365 && ms_s4 < SECS_PER_HOUR)
	`ASSERT_SAME(a_date_bound, clk, arst_n, v_s6,
		month_s6 != 4'd0 && month_s6 <= 4'd12 && day_s6 != 8'd0 && day_s6 <= 8'd31)
	`ASSERT_NEXT(a_entry, clk, arst_n, epoch_valid && epoch_ready, v_s1)

endmodule

`default_nettype wire
